FILE: hdl/rtc_set_command_parser_top_assert.svh
// Assertion macros for the RTC set-command parser.
// Included by rtc_set_command_parser_top; define ASSERT_OFF to drop them.
`ifndef RTC_SET_COMMAND_PARSER_TOP_ASSERT_SVH
`define RTC_SET_COMMAND_PARSER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(label, clk, rst, cond, prop)
`define ASSERT_NXT(label, clk, rst, cond, prop)
`endif
`endif

FILE: hdl/rscp_pkg.sv
// Types and constants of the RTC set-command parser.
// No dependencies; used by the parse logic and the top level.
`default_nettype none

package rscp_pkg;

  // Command letters (ASCII, case-sensitive)
  localparam logic [7:0] LETTER_TIME   = 8'h54;  // T
  localparam logic [7:0] LETTER_ALARM  = 8'h41;  // A
  localparam logic [7:0] LETTER_DATE   = 8'h44;  // D
  localparam logic [7:0] LETTER_REPORT = 8'h47;  // G
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_NINE    = 8'h39;
  localparam logic [7:0] ASCII_NUL     = 8'h00;

  // Result kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_TIME   = 3'd1;
  localparam logic [2:0] KIND_DATE   = 3'd2;
  localparam logic [2:0] KIND_ALARM  = 3'd3;
  localparam logic [2:0] KIND_REPORT = 3'd4;

  // Byte positions in a frame
  localparam logic [3:0] POS_LETTER      = 4'd0;
  localparam logic [3:0] POS_LAST_DIGIT  = 4'd7;
  // time and alarm frames
  localparam logic [3:0] POS_HOUR_TENS   = 4'd1;
  localparam logic [3:0] POS_HOUR_UNITS  = 4'd2;
  localparam logic [3:0] POS_MIN_TENS    = 4'd3;
  localparam logic [3:0] POS_MIN_UNITS   = 4'd4;
  localparam logic [3:0] POS_SEC_TENS    = 4'd5;
  localparam logic [3:0] POS_SEC_UNITS   = 4'd6;
  // date frames
  localparam logic [3:0] POS_WEEKDAY     = 4'd1;
  localparam logic [3:0] POS_YEAR_TENS   = 4'd2;
  localparam logic [3:0] POS_YEAR_UNITS  = 4'd3;
  localparam logic [3:0] POS_MONTH_TENS  = 4'd4;
  localparam logic [3:0] POS_MONTH_UNITS = 4'd5;
  localparam logic [3:0] POS_DAY_TENS    = 4'd6;
  localparam logic [3:0] POS_DAY_UNITS   = 4'd7;

  // Clamp limits
  localparam logic [6:0] HOUR_MAX  = 7'd23;
  localparam logic [6:0] MS_MAX    = 7'd59;
  localparam logic [6:0] YEAR_MAX  = 7'd31;
  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [6:0] DAY_MAX   = 7'd31;
  localparam logic [6:0] DAY_MIN   = 7'd1;

  typedef struct packed {
    logic [3:0] pos;
    logic [7:0] letter;
    logic       stopped;
  } frame_t;

  typedef struct packed {
    logic [5:0] time_hour;
    logic [5:0] time_minute;
    logic [5:0] time_second;
    logic [5:0] alarm_hour;
    logic [6:0] alarm_minute;
    logic [5:0] alarm_second;
    logic [2:0] date_weekday;
    logic [4:0] date_year;
    logic [3:0] date_month;
    logic [6:0] date_day;
  } fields_t;

  typedef struct packed {
    logic [2:0] cmd_kind;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
    logic [4:0] year;
    logic [3:0] month;
    logic [6:0] day;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/rscp_rx_if.sv
// Input channel of the RTC set-command parser: one received byte per word.
// No dependencies.
`default_nettype none

interface rscp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/rscp_res_if.sv
// Result channel of the RTC set-command parser: one frame summary per word.
// No dependencies.
`default_nettype none

interface rscp_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd_kind;
  logic [5:0] hour;
  logic [6:0] minute;
  logic [5:0] second;
  logic [2:0] weekday;
  logic [4:0] year;
  logic [3:0] month;
  logic [6:0] day;

  modport source (output valid, output cmd_kind, output hour, output minute,
                  output second, output weekday, output year, output month,
                  output day, input ready);
  modport sink   (input valid, input cmd_kind, input hour, input minute,
                  input second, input weekday, input year, input month,
                  input day, output ready);
endinterface

`default_nettype wire

FILE: hdl/rscp_parse.sv
// Combinational byte parser: next frame state, next stored fields and result.
// Depends on rscp_pkg.
`default_nettype none

module rscp_parse
  import rscp_pkg::*;
(
  input  wire logic [7:0] rx_byte,
  input  wire frame_t     frame,
  input  wire fields_t    fields,
  input  wire logic       frame_end,
  output frame_t          frame_next,
  output fields_t         fields_next,
  output result_t         result
);

  function automatic logic [6:0] times_ten(input logic [3:0] d);
    logic [6:0] x;
    begin
      x = {3'b000, d};
      times_ten = (x << 3) + (x << 1);
    end
  endfunction

  function automatic logic [6:0] add_clamp(input logic [6:0] v, input logic [3:0] d,
                                           input logic [6:0] top);
    logic [7:0] s;
    begin
      s = {1'b0, v} + {4'b0000, d};
      add_clamp = (s > {1'b0, top}) ? top : s[6:0];
    end
  endfunction

  logic       is_digit;
  logic [3:0] d;
  logic [6:0] tens;
  logic       take;
  logic [6:0] day_sum;

  assign is_digit = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
  assign d        = rx_byte[3:0];
  assign tens     = times_ten(d);
  assign day_sum  = add_clamp(fields.date_day, d, DAY_MAX);

  always_comb begin
    frame_next  = frame;
    fields_next = fields;
    take        = 1'b0;

    if (!frame.stopped) begin
      if (rx_byte == ASCII_NUL) begin
        frame_next.stopped = 1'b1;
      end else if (frame.pos == POS_LETTER) begin
        frame_next.letter = rx_byte;
      end else if (frame.pos <= POS_LAST_DIGIT && is_digit) begin
        take = 1'b1;
      end
    end

    if (take) begin
      case (frame.letter)
        LETTER_TIME: begin
          case (frame.pos)
            POS_HOUR_TENS:  if (d < 4'd6) fields_next.time_hour = 6'(tens);
            POS_HOUR_UNITS:
              fields_next.time_hour = 6'(add_clamp(7'(fields.time_hour), d, HOUR_MAX));
            POS_MIN_TENS:   if (d < 4'd6) fields_next.time_minute = 6'(tens);
            POS_MIN_UNITS:
              fields_next.time_minute = 6'(add_clamp(7'(fields.time_minute), d, MS_MAX));
            POS_SEC_TENS:   if (d < 4'd6) fields_next.time_second = 6'(tens);
            POS_SEC_UNITS:
              fields_next.time_second = 6'(add_clamp(7'(fields.time_second), d, MS_MAX));
            default: ;
          endcase
        end
        LETTER_ALARM: begin
          case (frame.pos)
            POS_HOUR_TENS:  if (d < 4'd6) fields_next.alarm_hour = 6'(tens);
            POS_HOUR_UNITS:
              fields_next.alarm_hour = 6'(add_clamp(7'(fields.alarm_hour), d, HOUR_MAX));
            POS_MIN_TENS:   fields_next.alarm_minute = tens;
            POS_MIN_UNITS:
              fields_next.alarm_minute = add_clamp(fields.alarm_minute, d, MS_MAX);
            POS_SEC_TENS:   if (d < 4'd6) fields_next.alarm_second = 6'(tens);
            POS_SEC_UNITS:
              if (d < 4'd6) begin
                fields_next.alarm_second =
                  6'(add_clamp(7'(fields.alarm_second), d, MS_MAX));
              end
            default: ;
          endcase
        end
        LETTER_DATE: begin
          case (frame.pos)
            POS_WEEKDAY:
              if (d >= 4'd1 && d <= 4'd7) fields_next.date_weekday = d[2:0];
            POS_YEAR_TENS:
              if (d >= 4'd1 && d <= 4'd2) fields_next.date_year = 5'(tens);
            POS_YEAR_UNITS:
              fields_next.date_year = 5'(add_clamp(7'(fields.date_year), d, YEAR_MAX));
            POS_MONTH_TENS: if (d <= 4'd1) fields_next.date_month = 4'(tens);
            POS_MONTH_UNITS:
              fields_next.date_month = 4'(add_clamp(7'(fields.date_month), d, MONTH_MAX));
            POS_DAY_TENS:   fields_next.date_day = tens;
            POS_DAY_UNITS:
              fields_next.date_day = (day_sum < DAY_MIN) ? DAY_MIN : day_sum;
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // Result reflects this byte's update; frame state starts over after a frame's last byte
    result         = '0;
    result.weekday = fields_next.date_weekday;
    result.year    = fields_next.date_year;
    result.month   = fields_next.date_month;
    result.day     = fields_next.date_day;
    case (frame_next.letter)
      LETTER_TIME: begin
        result.cmd_kind = KIND_TIME;
        result.hour     = fields_next.time_hour;
        result.minute   = 7'(fields_next.time_minute);
        result.second   = fields_next.time_second;
      end
      LETTER_ALARM: begin
        result.cmd_kind = KIND_ALARM;
        result.hour     = fields_next.alarm_hour;
        result.minute   = fields_next.alarm_minute;
        result.second   = fields_next.alarm_second;
      end
      LETTER_DATE:   result.cmd_kind = KIND_DATE;
      LETTER_REPORT: result.cmd_kind = KIND_REPORT;
      default:       result.cmd_kind = KIND_NONE;
    endcase

    if (frame_end) begin
      frame_next = '0;
    end else begin
      frame_next.pos = frame.pos + 4'd1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rtc_set_command_parser_top.sv
// RTC set-command parser, top level. Depends on rscp_pkg, rscp_rx_if,
// rscp_res_if, rscp_parse and rtc_set_command_parser_top_assert.svh.
// A result word is registered: the last byte of a frame passes the input
// register, then is parsed into the result register. Throughput: one byte
// per cycle unless a frame's last byte waits on a full result slot, one result word per FRAME_BYTES bytes.
// Reset: synchronous, active high; clears frame state and all stored fields.
`default_nettype none

`include "rtc_set_command_parser_top_assert.svh"

module rtc_set_command_parser_top
  import rscp_pkg::*;
#(
  parameter int FRAME_BYTES = 12  // 8..16
) (
  input wire logic  clk,
  input wire logic  rst,
  rscp_rx_if.sink   rx,
  rscp_res_if.source res
);

  localparam logic [3:0] LAST_POS = 4'(FRAME_BYTES - 1);

  // Input register: one byte waiting for the parse stage
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Frame tracking and stored fields
  frame_t  frame;
  frame_t  frame_next;
  fields_t fields;
  fields_t fields_next;
  result_t result;

  // Result register
  logic    out_valid;
  result_t res_q;

  logic frame_end;
  logic proc;
  logic out_load;

  assign frame_end = (frame.pos == LAST_POS);

  // The parse stage runs whenever the result slot is free or being drained,
  // so a pending result never blocks bytes until a second one is due.
  assign proc     = s1_valid && (!frame_end || !out_valid || res.ready);
  assign out_load = proc && frame_end;
  assign rx.ready = !s1_valid || proc;

  rscp_parse u_parse (
    .rx_byte     (s1_byte),
    .frame       (frame),
    .fields      (fields),
    .frame_end   (frame_end),
    .frame_next  (frame_next),
    .fields_next (fields_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      frame     <= '0;
      fields    <= '0;
    end else begin
      if (rx.ready) begin
        s1_valid <= rx.valid;
      end
      if (proc) begin
        frame  <= frame_next;
        fields <= fields_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
    if (out_load) begin
      res_q <= result;
    end
  end

  assign res.valid    = out_valid;
  assign res.cmd_kind = res_q.cmd_kind;
  assign res.hour     = res_q.hour;
  assign res.minute   = res_q.minute;
  assign res.second   = res_q.second;
  assign res.weekday  = res_q.weekday;
  assign res.year     = res_q.year;
  assign res.month    = res_q.month;
  assign res.day      = res_q.day;

  // A stalled input byte is neither lost nor overwritten.
  `ASSERT_NXT(a_s1_hold, clk, rst, s1_valid && !proc, s1_valid && $stable(s1_byte))
  // After the last byte of a frame the tracker starts a fresh frame.
  `ASSERT_NXT(a_frame_restart, clk, rst, out_load, frame.pos == POS_LETTER && !frame.stopped)
  // Kinds other than time and alarm report zero time fields.
  `ASSERT_IMP(a_time_zero, clk, rst,
              res.valid && res.cmd_kind != KIND_TIME && res.cmd_kind != KIND_ALARM,
              res.hour == 6'd0 && res.minute == 7'd0 && res.second == 6'd0)

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Testbench for rtc_set_command_parser_top: directed frames from a table, then random
// frames, with every result word checked against an in-bench parser model.
// Depends on rscp_pkg, rscp_rx_if, rscp_res_if and the RTL of the parser.

module testbench;
  import rscp_pkg::*;

  localparam int FRAME_LEN = 12;
  localparam int END_DRAIN = 8;          // cycles after last result, covers pipe latency
  localparam int HOLD_CYCLES = 300;      // long result stall, frames pile up behind it
  localparam int RANDOM_FRAMES = 24;     // ~290 bytes
  localparam logic [7:0] NUL_MARK = 8'h5F;  // '_' in table text stands for a NUL byte

  // Directed row: text is right-aligned, leading zero bytes are padding.
  // Bytes after the text up to the frame length are the fill byte.
  typedef struct packed {
    logic [63:0] text;
    logic [7:0]  fill;
    logic        given;
    result_t     want;
  } frame_row_t;

  // Per directed frame: the typed answer, if any, overrides the model's.
  typedef struct packed {
    logic    given;
    result_t word;
  } answer_t;

  logic clk = 1'b0;
  logic rst;
  logic calm;           // both sides run without gaps
  logic hold_off_req;   // asks the receiver for one long stall

  rscp_rx_if  rx_ch ();
  rscp_res_if res_ch ();

  rtc_set_command_parser_top #(
    .FRAME_BYTES(FRAME_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .res(res_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser model: frame position, letter, stop flag and stored fields.
  // ---------------------------------------------------------------------------
  logic [3:0] at_pos     = '0;
  logic [7:0] cur_letter = '0;
  logic       halted     = 1'b0;
  logic [5:0] tm_hour = '0, tm_min = '0, tm_sec = '0;
  logic [5:0] al_hour = '0, al_sec = '0;
  logic [6:0] al_min  = '0;
  logic [2:0] dt_wday  = '0;
  logic [4:0] dt_year  = '0;
  logic [3:0] dt_month = '0;
  logic [6:0] dt_day   = '0;

  result_t pending_summaries [$];   // frame summaries still owed by the block
  answer_t directed_answers [$];
  int      faults = 0;

  function automatic int unsigned clamp_add(int unsigned v, int unsigned d,
                                            int unsigned top);
    return (v + d > top) ? top : v + d;
  endfunction

  // One digit at one frame position; positions with a range check drop an out-of-range digit.
  task automatic take_digit_at(input logic [3:0] p, input int unsigned d);
    case (cur_letter)
      LETTER_TIME: begin
        case (p)
          POS_HOUR_TENS:  if (d < 6) tm_hour = 6'(10 * d);
          POS_HOUR_UNITS: tm_hour = 6'(clamp_add(tm_hour, d, HOUR_MAX));
          POS_MIN_TENS:   if (d < 6) tm_min = 6'(10 * d);
          POS_MIN_UNITS:  tm_min = 6'(clamp_add(tm_min, d, MS_MAX));
          POS_SEC_TENS:   if (d < 6) tm_sec = 6'(10 * d);
          POS_SEC_UNITS:  tm_sec = 6'(clamp_add(tm_sec, d, MS_MAX));
          default: ;
        endcase
      end
      LETTER_ALARM: begin
        case (p)
          POS_HOUR_TENS:  if (d < 6) al_hour = 6'(10 * d);
          POS_HOUR_UNITS: al_hour = 6'(clamp_add(al_hour, d, HOUR_MAX));
          POS_MIN_TENS:   al_min = 7'(10 * d);
          POS_MIN_UNITS:  al_min = 7'(clamp_add(al_min, d, MS_MAX));
          POS_SEC_TENS:   if (d < 6) al_sec = 6'(10 * d);
          POS_SEC_UNITS:  if (d < 6) al_sec = 6'(clamp_add(al_sec, d, MS_MAX));
          default: ;
        endcase
      end
      LETTER_DATE: begin
        case (p)
          POS_WEEKDAY:     if (d >= 1 && d <= 7) dt_wday = 3'(d);
          POS_YEAR_TENS:   if (d >= 1 && d <= 2) dt_year = 5'(10 * d);
          POS_YEAR_UNITS:  dt_year = 5'(clamp_add(dt_year, d, YEAR_MAX));
          POS_MONTH_TENS:  if (d <= 1) dt_month = 4'(10 * d);
          POS_MONTH_UNITS: dt_month = 4'(clamp_add(dt_month, d, MONTH_MAX));
          POS_DAY_TENS:    dt_day = 7'(10 * d);
          POS_DAY_UNITS: begin
            dt_day = 7'(clamp_add(dt_day, d, DAY_MAX));
            if (dt_day < DAY_MIN) dt_day = DAY_MIN;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  // Feed one accepted byte; the last byte of a frame owes one summary word.
  task automatic absorb_byte(input logic [7:0] b);
    logic [3:0] p;
    result_t    s;
    answer_t    ans;
    p = at_pos;
    if (!halted) begin
      if (b == ASCII_NUL) halted = 1'b1;
      else if (p == POS_LETTER) cur_letter = b;
      else if (p <= POS_LAST_DIGIT && b >= ASCII_ZERO && b <= ASCII_NINE)
        take_digit_at(p, b - ASCII_ZERO);
    end
    if (p + 1 < FRAME_LEN) begin
      at_pos = p + 4'd1;
      return;
    end
    s = '0;
    case (cur_letter)
      LETTER_TIME: begin
        s.cmd_kind = KIND_TIME;
        s.hour     = tm_hour;
        s.minute   = {1'b0, tm_min};
        s.second   = tm_sec;
      end
      LETTER_ALARM: begin
        s.cmd_kind = KIND_ALARM;
        s.hour     = al_hour;
        s.minute   = al_min;
        s.second   = al_sec;
      end
      LETTER_DATE:   s.cmd_kind = KIND_DATE;
      LETTER_REPORT: s.cmd_kind = KIND_REPORT;
      default:       s.cmd_kind = KIND_NONE;
    endcase
    s.weekday = dt_wday;
    s.year    = dt_year;
    s.month   = dt_month;
    s.day     = dt_day;
    if (directed_answers.size() != 0) begin
      ans = directed_answers.pop_front();
      if (ans.given) s = ans.word;
    end
    pending_summaries.push_back(s);
    at_pos     = POS_LETTER;
    cur_letter = ASCII_NUL;
    halted     = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  function automatic void match_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      faults++;
    end
  endfunction

  task automatic check_summary(input result_t got);
    result_t want;
    if (pending_summaries.size() == 0) begin
      $display("%0t: result word with nothing expected, expected none, actual kind %0d",
               $time, got.cmd_kind);
      faults++;
      return;
    end
    want = pending_summaries.pop_front();
    match_field("cmd_kind", want.cmd_kind, got.cmd_kind);
    match_field("hour",     want.hour,     got.hour);
    match_field("minute",   want.minute,   got.minute);
    match_field("second",   want.second,   got.second);
    match_field("weekday",  want.weekday,  got.weekday);
    match_field("year",     want.year,     got.year);
    match_field("month",    want.month,    got.month);
    match_field("day",      want.day,      got.day);
  endtask

  // Both channels sampled at the edge; every driven signal changes by NBA, so
  // the values read here are the ones the block saw at this edge.
  // Result check goes first so a word cannot be matched to its own frame's
  // expectation pushed in the same step.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        check_summary({res_ch.cmd_kind, res_ch.hour, res_ch.minute, res_ch.second,
                       res_ch.weekday, res_ch.year, res_ch.month, res_ch.day});
      if (rx_ch.valid && rx_ch.ready) absorb_byte(rx_ch.rx_byte);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        // sender keeps offering bytes here, so the block fills and stalls rx
        repeat (HOLD_CYCLES) begin
          res_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      res_ch.ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one byte, with random gaps, and return on the edge that takes it.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 13) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
  endtask

  task automatic send_row(input frame_row_t r);
    logic [7:0] c;
    int         n;
    n = 0;
    for (int k = 7; k >= 0; k--) begin
      c = r.text[8*k +: 8];
      if (c != 8'h00) begin
        send_byte((c == NUL_MARK) ? ASCII_NUL : c);
        n++;
      end
    end
    while (n < FRAME_LEN) begin
      send_byte(r.fill);
      n++;
    end
  endtask

  // Mostly well-formed frames with random digits; some broken by a NUL, some noise.
  task automatic send_random_frame();
    logic [7:0] b;
    int         cut;
    logic       noise;
    noise = ($urandom_range(99) < 15);
    cut   = ($urandom_range(99) < 12) ? $urandom_range(FRAME_LEN - 1) : FRAME_LEN;
    for (int p = 0; p < FRAME_LEN; p++) begin
      if (noise) b = 8'($urandom_range(255));
      else if (p == cut) b = ASCII_NUL;
      else if (p == POS_LETTER) begin
        case ($urandom_range(7))
          0, 1:    b = LETTER_TIME;
          2, 3:    b = LETTER_DATE;
          4, 5:    b = LETTER_ALARM;
          6:       b = LETTER_REPORT;
          default: b = 8'($urandom_range(255));
        endcase
      end else if (p <= POS_LAST_DIGIT)
        b = ($urandom_range(99) < 90) ? 8'(ASCII_ZERO + $urandom_range(9))
                                      : 8'($urandom_range(255));
      else b = 8'($urandom_range(255));
      send_byte(b);
    end
  endtask

  // Directed frames. Typed answers only where the stored fields are obvious.
  frame_row_t frame_script [18] = '{
    // report right after reset: everything zero
    '{"G",        8'hFF, 1'b1, '{KIND_REPORT, 6'd0, 7'd0, 6'd0, 3'd0, 5'd0, 4'd0, 7'd0}},
    '{"T235959",  8'hFF, 1'b1, '{KIND_TIME, 6'd23, 7'd59, 6'd59, 3'd0, 5'd0, 4'd0, 7'd0}},
    '{"T000000",  8'hFF, 1'b1, '{KIND_TIME, 6'd0, 7'd0, 6'd0, 3'd0, 5'd0, 4'd0, 7'd0}},
    // hour clamp, rejected tens digits keep old minute/second
    '{"T599999",  8'hFF, 1'b0, '0},
    // tens without units: hour left at 50
    '{"T5_",      8'hFF, 1'b0, '0},
    // NUL as the very first byte: no letter, kind none
    '{"_T23",     8'hFF, 1'b1, '{KIND_NONE, 6'd0, 7'd0, 6'd0, 3'd0, 5'd0, 4'd0, 7'd0}},
    '{"A239959",  8'hFF, 1'b0, '0},
    '{"A5_",      8'hFF, 1'b0, '0},
    '{"D7291231", 8'hFF, 1'b1, '{KIND_DATE, 6'd0, 7'd0, 6'd0, 3'd7, 5'd29, 4'd12, 7'd31}},
    '{"D1199999", 8'hFF, 1'b0, '0},
    // day units on zero tens: forced up to 1
    '{"D0000000", 8'hFF, 1'b0, '0},
    // rejected year tens, units still added, then saturates
    '{"D139",     8'hFF, 1'b0, '0},
    '{"D889",     8'hFF, 1'b0, '0},
    '{"D889",     8'hFF, 1'b0, '0},
    // lowercase letter is unknown
    '{"t235959",  8'hFF, 1'b0, '0},
    // digits past position 7 are ignored
    '{"G1234567", "9",   1'b0, '0},
    '{"T1234567", 8'h00, 1'b0, '0},
    '{"Z",        8'hFF, 1'b0, '0}
  };

  initial begin
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    calm          <= 1'b0;
    hold_off_req  <= 1'b0;
    // answers queued up front, one per directed frame, in frame order
    foreach (frame_script[i])
      directed_answers.push_back('{frame_script[i].given, frame_script[i].want});
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (frame_script[i]) send_row(frame_script[i]);

    // sender pause: let every summary come back before the random part
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_summaries.size() != 0);

    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      if (f == 4) calm <= 1'b1;
      if (f == 12) calm <= 1'b0;
      if (f == 14) hold_off_req <= 1'b1;
      if (f == 19) begin
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_summaries.size() != 0);
      end
      send_random_frame();
    end

    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_summaries.size() != 0);
    repeat (END_DRAIN) @(posedge clk);
    if (faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
